[hdl/cse_pkg.sv]
`timescale 1ns / 1ps
package cse_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CH_W        = 8;
    localparam int NUM_LANES   = 3;
    localparam int PIX_W       = CH_W * NUM_LANES;
    localparam int MAG_W       = 9;
    localparam int BIN_W       = 2;
    localparam int LANE_W      = MAG_W + BIN_W;
    localparam int EDGE_W      = LANE_W * NUM_LANES;
    localparam int OUT_W       = PIX_W + 1;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;
    localparam int ADDR_W      = 4;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;
    localparam logic [8:0]  THRESH_RESET = 9'd30;

    localparam logic [1:0] REG_IDX_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IDX_HEIGHT = 2'd1;
    localparam logic [1:0] REG_IDX_THRESH = 2'd2;

    localparam logic [BIN_W-1:0] BIN_HORIZ = 2'd0;
    localparam logic [BIN_W-1:0] BIN_DIAG1 = 2'd1;
    localparam logic [BIN_W-1:0] BIN_VERT  = 2'd2;
    localparam logic [BIN_W-1:0] BIN_DIAG3 = 2'd3;

    localparam logic [6:0]  TAN_LOW_Q8  = 7'd106;
    localparam logic [9:0]  TAN_HIGH_Q8 = 10'd618;
    localparam logic [15:0] DIV6_RECIP  = 16'd43691;
    localparam int          DIV6_SHIFT  = 18;

    typedef logic [COL_W-1:0] col_t;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] mag;
    } edge_lane_t;

    typedef struct packed {
        logic upd;
        logic grad_en;
        logic out_en;
        logic inner;
        logic last;
        col_t qc;
    } stage_ctrl_t;

endpackage

[hdl/cse_grad_lane.sv]
`timescale 1ns / 1ps
module cse_grad_lane (
    input  logic                                aclk,
    input  logic [8:0][cse_pkg::CH_W-1:0]       win,
    output cse_pkg::edge_lane_t                 grad
);
    import cse_pkg::*;

    logic signed [11:0] p [9];
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic signed [11:0] gx_abs;
    logic signed [11:0] gy_abs;
    logic [9:0]  ax_reg;
    logic [9:0]  ay_reg;
    logic        gx_zero_reg;
    logic        gx_pos_reg;
    logic        gy_pos_reg;
    logic [10:0] sum;
    logic [26:0] prod;
    logic [19:0] ay_scaled;
    logic [19:0] ax_low;
    logic [19:0] ax_high;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            p[i] = $signed({4'b0000, win[i]});
        end
        gx = p[2] + (p[5] <<< 1) + p[8] - p[0] - (p[3] <<< 1) - p[6];
        gy = p[6] + (p[7] <<< 1) + p[8] - p[0] - (p[1] <<< 1) - p[2];
        gx_abs = gx[11] ? -gx : gx;
        gy_abs = gy[11] ? -gy : gy;
    end

    always_ff @(posedge aclk) begin
        ax_reg      <= gx_abs[9:0];
        ay_reg      <= gy_abs[9:0];
        gx_zero_reg <= (gx == 12'sd0);
        gx_pos_reg  <= (gx > 12'sd0);
        gy_pos_reg  <= (gy > 12'sd0);
    end

    // magnitude /6 by reciprocal, exact over the 11-bit sum range
    always_comb begin
        sum       = {1'b0, ax_reg} + {1'b0, ay_reg};
        prod      = {16'd0, sum} * {11'd0, DIV6_RECIP};
        ay_scaled = {2'b00, ay_reg, 8'd0};
        ax_low    = {10'd0, ax_reg} * {13'd0, TAN_LOW_Q8};
        ax_high   = {10'd0, ax_reg} * {10'd0, TAN_HIGH_Q8};
        grad.mag  = prod[DIV6_SHIFT +: MAG_W];
        if (gx_zero_reg) begin
            grad.bin = BIN_VERT;
        end else if (ay_scaled < ax_low) begin
            grad.bin = BIN_HORIZ;
        end else if (ay_scaled < ax_high) begin
            grad.bin = (gx_pos_reg == gy_pos_reg) ? BIN_DIAG1 : BIN_DIAG3;
        end else begin
            grad.bin = BIN_VERT;
        end
    end

endmodule

[hdl/cse_nms_lane.sv]
`timescale 1ns / 1ps
module cse_nms_lane (
    input  cse_pkg::edge_lane_t [8:0]      win,
    input  logic [cse_pkg::MAG_W-1:0]      threshold,
    input  logic                           inner,
    output logic [cse_pkg::CH_W-1:0]       edge_out
);
    import cse_pkg::*;

    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] side_a;
    logic [MAG_W-1:0] side_b;

    always_comb begin
        m = win[4].mag;
        case (win[4].bin)
            BIN_HORIZ: begin
                side_a = win[3].mag;
                side_b = win[5].mag;
            end
            BIN_DIAG1: begin
                side_a = win[2].mag;
                side_b = win[6].mag;
            end
            BIN_VERT: begin
                side_a = win[1].mag;
                side_b = win[7].mag;
            end
            default: begin
                side_a = win[0].mag;
                side_b = win[8].mag;
            end
        endcase
        if (!inner || m < threshold || m < side_a || m < side_b) begin
            edge_out = '0;
        end else if (m > MAG_W'(255)) begin
            edge_out = 8'hFF;
        end else begin
            edge_out = m[CH_W-1:0];
        end
    end

endmodule

[hdl/cse_out_fifo.sv]
`timescale 1ns / 1ps
module cse_out_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  logic [cse_pkg::OUT_W-1:0]         push_data,
    input  logic                              pop,
    output logic [cse_pkg::OUT_W-1:0]         head_data,
    output logic                              not_empty,
    output logic [cse_pkg::FIFO_CNT_W-1:0]    count
);
    import cse_pkg::*;

    logic [OUT_W-1:0]      mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wptr_reg;
    logic [FIFO_PTR_W-1:0] rptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign head_data = mem_reg[rptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/color_sobel_edge_nms.sv]
`timescale 1ns / 1ps
// colour sobel edge detector with non-maximum suppression
// s_ channel: one transaction per pixel in raster order (s_tuser low) or one
// drain transaction (s_tuser high) per pending result after the frame's last
// pixel; red, green and blue each run through their own gradient and
// suppression lane, and a merge stage packs the three lanes into one result
// m_ channel: one result per accepted transaction once 2*width+2 positions
// have gone in; m_tlast marks the final position of the frame
// once its transaction is accepted, a result passes the pixel window, gradient
// register, edge window and output queue before it is visible on m_
// throughput: one transaction per cycle while s_tready is high, set by the
// dual-port line stores that are read and written once per pixel
// stall: results collect in an 8-entry output queue; s_tready drops only when
// the queue and the results still in the pipeline fill all 8 entries
// reset: frame counters to zero, registers to 640 x 480 with threshold 30,
// windows cleared and queue emptied; line stores are not cleared
// a register write over apb restarts the frame
module color_sobel_edge_nms (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // red, green, blue
    input  logic                       s_tuser,   // command
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // red_edge, green_edge, blue_edge
    output logic                       m_tlast,   // last_of_frame
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cse_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import cse_pkg::*;

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [8:0]  thresh_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    logic [10:0] w_eff;
    logic [15:0] h_eff;
    logic [10:0] w_m1;
    logic [10:0] w_m2;
    logic [15:0] h_m1;
    logic [15:0] h_m2;

    col_t        tc_reg, tc_next;
    logic [16:0] tr_reg, tr_next;
    col_t        oc_reg, oc_next;
    logic [15:0] or_reg, or_next;

    logic        in_acc;
    logic        drain;
    logic        live;
    logic        out_en;
    logic        inner;
    logic        last;
    logic        grad_en;
    col_t        qc;
    logic [10:0] tc_inc;
    logic [10:0] oc_inc;

    logic [2*PIX_W-1:0]  pmem [MAX_WIDTH];
    logic [2*PIX_W-1:0]  prd_reg;
    logic [2*PIX_W-1:0]  pwdata_mem;
    logic                pwe;
    logic [PIX_W-1:0]    pwin_reg [9];

    logic [2*EDGE_W-1:0] emem [MAX_WIDTH];
    logic [2*EDGE_W-1:0] erd_reg;
    logic [2*EDGE_W-1:0] ewdata;
    logic                ewe;
    logic [EDGE_W-1:0]   edge_b;
    logic [EDGE_W-1:0]   ewin_reg [9];

    stage_ctrl_t a_ctrl_reg, a_ctrl_next;
    stage_ctrl_t b_ctrl_reg;
    stage_ctrl_t c_ctrl_reg;

    edge_lane_t [NUM_LANES-1:0] grad;
    logic [NUM_LANES-1:0][CH_W-1:0] nms_out;

    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   pending;
    logic [OUT_W-1:0]      fifo_head;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready &&
                     (cfg_idx == REG_IDX_WIDTH || cfg_idx == REG_IDX_HEIGHT ||
                      cfg_idx == REG_IDX_THRESH);

    always_comb begin
        case (cfg_idx)
            REG_IDX_WIDTH:  prdata = {21'd0, width_reg};
            REG_IDX_HEIGHT: prdata = {16'd0, height_reg};
            REG_IDX_THRESH: prdata = {23'd0, thresh_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IDX_WIDTH:  width_reg  <= pwdata[10:0];
                REG_IDX_HEIGHT: height_reg <= pwdata[15:0];
                default:        thresh_reg <= pwdata[8:0];
            endcase
        end
    end

    always_comb begin
        if (width_reg < 11'd3) begin
            w_eff = 11'd3;
        end else if (width_reg > 11'(MAX_WIDTH)) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg < 16'd3) ? 16'd3 : height_reg;
        w_m1  = w_eff - 11'd1;
        w_m2  = w_eff - 11'd2;
        h_m1  = h_eff - 16'd1;
        h_m2  = h_eff - 16'd2;
    end

    // input side control
    assign pending  = {1'b0, fifo_count} + (FIFO_CNT_W+1)'(a_ctrl_reg.out_en)
                    + (FIFO_CNT_W+1)'(b_ctrl_reg.out_en) + (FIFO_CNT_W+1)'(c_ctrl_reg.out_en);
    assign s_tready = (pending < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign in_acc   = s_tvalid && s_tready;
    assign drain    = s_tuser;
    assign live     = in_acc && (drain == (tr_reg >= {1'b0, h_eff}));

    always_comb begin
        tc_inc  = {1'b0, tc_reg} + 11'd1;
        oc_inc  = {1'b0, oc_reg} + 11'd1;
        out_en  = !(tr_reg < 17'd2 || (tr_reg == 17'd2 && tc_reg < col_t'(2)));
        inner   = (or_reg >= 16'd1) && (or_reg <= h_m2) && (oc_reg >= col_t'(1)) &&
                  ({1'b0, oc_reg} <= w_m2);
        last    = (or_reg == h_m1) && ({1'b0, oc_reg} == w_m1);
        grad_en = !drain && (tr_reg >= 17'd2) && (tc_reg >= col_t'(2));
        qc      = (tc_reg == '0) ? w_m1[COL_W-1:0] : tc_reg - col_t'(1);

        tc_next = tc_reg;
        tr_next = tr_reg;
        oc_next = oc_reg;
        or_next = or_reg;
        if (cfg_wr) begin
            tc_next = '0;
            tr_next = '0;
            oc_next = '0;
            or_next = '0;
        end else if (live) begin
            if (tc_inc >= w_eff) begin
                tc_next = '0;
                tr_next = tr_reg + 17'd1;
            end else begin
                tc_next = tc_inc[COL_W-1:0];
            end
            if (out_en) begin
                if (oc_inc >= w_eff) begin
                    oc_next = '0;
                    or_next = or_reg + 16'd1;
                end else begin
                    oc_next = oc_inc[COL_W-1:0];
                end
                if (last) begin
                    tc_next = '0;
                    tr_next = '0;
                    oc_next = '0;
                    or_next = '0;
                end
            end
        end

        a_ctrl_next.upd     = live;
        a_ctrl_next.grad_en = grad_en;
        a_ctrl_next.out_en  = live && out_en;
        a_ctrl_next.inner   = inner;
        a_ctrl_next.last    = last;
        a_ctrl_next.qc      = qc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg     <= '0;
            tr_reg     <= '0;
            oc_reg     <= '0;
            or_reg     <= '0;
            a_ctrl_reg <= '0;
            b_ctrl_reg <= '0;
            c_ctrl_reg <= '0;
        end else begin
            tc_reg     <= tc_next;
            tr_reg     <= tr_next;
            oc_reg     <= oc_next;
            or_reg     <= or_next;
            a_ctrl_reg <= a_ctrl_next;
            b_ctrl_reg <= a_ctrl_reg;
            c_ctrl_reg <= b_ctrl_reg;
        end
    end

    // pixel line store: entry holds the two older rows of one column
    assign pwe        = live && !drain;
    assign pwdata_mem = {s_tdata, prd_reg[2*PIX_W-1:PIX_W]};

    always_ff @(posedge aclk) begin
        if (pwe) begin
            pmem[tc_reg] <= pwdata_mem;
        end
        if (pwe && tc_reg == tc_next) begin
            prd_reg <= pwdata_mem;
        end else begin
            prd_reg <= pmem[tc_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                pwin_reg[i] <= '0;
            end
        end else if (pwe) begin
            for (int r = 0; r < 3; r++) begin
                pwin_reg[r*3]   <= pwin_reg[r*3+1];
                pwin_reg[r*3+1] <= pwin_reg[r*3+2];
            end
            pwin_reg[2] <= prd_reg[PIX_W-1:0];
            pwin_reg[5] <= prd_reg[2*PIX_W-1:PIX_W];
            pwin_reg[8] <= s_tdata;
        end
    end

    // gradient lanes
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_grad
        logic [8:0][CH_W-1:0] lane_win;
        for (genvar i = 0; i < 9; i++) begin : g_tap
            assign lane_win[i] = pwin_reg[i][k*CH_W +: CH_W];
        end
        cse_grad_lane u_grad (
            .aclk (aclk),
            .win  (lane_win),
            .grad (grad[k])
        );
    end

    // edge line store and edge window
    assign ewe    = b_ctrl_reg.upd;
    assign edge_b = b_ctrl_reg.grad_en ? EDGE_W'(grad) : '0;
    assign ewdata = {edge_b, erd_reg[2*EDGE_W-1:EDGE_W]};

    always_ff @(posedge aclk) begin
        if (ewe) begin
            emem[b_ctrl_reg.qc] <= ewdata;
        end
        if (ewe && b_ctrl_reg.qc == a_ctrl_reg.qc) begin
            erd_reg <= ewdata;
        end else begin
            erd_reg <= emem[a_ctrl_reg.qc];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                ewin_reg[i] <= '0;
            end
        end else if (ewe) begin
            for (int r = 0; r < 3; r++) begin
                ewin_reg[r*3]   <= ewin_reg[r*3+1];
                ewin_reg[r*3+1] <= ewin_reg[r*3+2];
            end
            ewin_reg[2] <= erd_reg[EDGE_W-1:0];
            ewin_reg[5] <= erd_reg[2*EDGE_W-1:EDGE_W];
            ewin_reg[8] <= edge_b;
        end
    end

    // suppression lanes
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_nms
        edge_lane_t [8:0] lane_win;
        for (genvar i = 0; i < 9; i++) begin : g_tap
            assign lane_win[i] = ewin_reg[i][k*LANE_W +: LANE_W];
        end
        cse_nms_lane u_nms (
            .win       (lane_win),
            .threshold (thresh_reg),
            .inner     (c_ctrl_reg.inner),
            .edge_out  (nms_out[k])
        );
    end

    // merge lanes into the output queue
    cse_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (c_ctrl_reg.out_en),
        .push_data ({c_ctrl_reg.last, nms_out}),
        .pop       (m_tready),
        .head_data (fifo_head),
        .not_empty (m_tvalid),
        .count     (fifo_count)
    );

    assign m_tdata = fifo_head[PIX_W-1:0];
    assign m_tlast = fifo_head[PIX_W];

endmodule

[hdl/cse_checker.sv]
`timescale 1ns / 1ps
module cse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        pready
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("queue not empty or input blocked after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("apb wait state inserted");

endmodule

bind color_sobel_edge_nms cse_checker u_cse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

[tb/color_sobel_edge_nms_tb.sv]
`timescale 1ns / 1ps
module color_sobel_edge_nms_tb;
    import cse_pkg::*;

    typedef struct {
        bit       drain;
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
    } pixel_txn_t;

    typedef struct {
        bit [23:0] edges;
        bit        last;
    } edge_txn_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    color_sobel_edge_nms DUT (.*);

    always #1 aclk = ~aclk;

    pixel_txn_t pixel_q[$];
    edge_txn_t  edge_q[$];
    int         err_count = 0;
    int         idle_mode = 0;
    int         items_sent = 0;

    // shadow of the block
    bit [10:0]   cfg_width = WIDTH_RESET;
    bit [15:0]   cfg_height = HEIGHT_RESET;
    bit [8:0]    cfg_thresh = THRESH_RESET;
    bit [23:0]   pix_line [0:2*MAX_WIDTH-1];
    bit [32:0]   edge_line [0:2*MAX_WIDTH-1];
    bit [23:0]   pix_win [9];
    bit [32:0]   edge_win [9];
    int          in_col, in_row, out_col, out_row;

    function automatic int width_used();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return int'(cfg_width);
    endfunction

    function automatic int height_used();
        return cfg_height < 3 ? 3 : int'(cfg_height);
    endfunction

    function automatic bit [10:0] lane_gradient(int k);
        int p[9];
        int gx, gy, ax, ay;
        bit [8:0] mag;
        bit [1:0] bin;
        for (int i = 0; i < 9; i++) p[i] = int'(pix_win[i][8*k +: 8]);
        gx = -p[0] - 2*p[3] - p[6] + p[2] + 2*p[5] + p[8];
        gy = -p[0] - 2*p[1] - p[2] + p[6] + 2*p[7] + p[8];
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        mag = 9'((ax + ay) / 6);
        if (gx == 0) bin = BIN_VERT;
        else if (ay * 256 < int'(TAN_LOW_Q8) * ax) bin = BIN_HORIZ;
        else if (ay * 256 < int'(TAN_HIGH_Q8) * ax)
            bin = ((gx > 0) == (gy > 0)) ? BIN_DIAG1 : BIN_DIAG3;
        else bin = BIN_VERT;
        return {bin, mag};
    endfunction

    function automatic bit [7:0] lane_suppress(int k);
        bit [8:0] m;
        int b;
        m = edge_win[4][11*k +: 9];
        b = int'(edge_win[4][11*k+9 +: 2]);
        if (m < cfg_thresh) return 8'd0;
        if (m < edge_win[3-b][11*k +: 9]) return 8'd0;
        if (m < edge_win[5+b][11*k +: 9]) return 8'd0;
        return m > 255 ? 8'd255 : m[7:0];
    endfunction

    function automatic void restart_frame();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function automatic void predict_edges(pixel_txn_t t);
        int w, h, tr, tc, col, qc, orow, ocol;
        bit [23:0] pcol [3];
        bit [32:0] ecol [3];
        bit [32:0] grad;
        bit inner;
        edge_txn_t e;
        w = width_used(); h = height_used();
        tr = in_row; tc = in_col;
        grad = '0;
        if (t.drain != (tr >= h)) return;
        if (!t.drain) begin
            col = tc % MAX_WIDTH;
            pcol[0] = pix_line[col];
            pcol[1] = pix_line[MAX_WIDTH + col];
            pcol[2] = {t.blue, t.green, t.red};
            pix_line[col] = pcol[1];
            pix_line[MAX_WIDTH + col] = pcol[2];
            for (int r = 0; r < 3; r++) begin
                pix_win[r*3] = pix_win[r*3+1];
                pix_win[r*3+1] = pix_win[r*3+2];
                pix_win[r*3+2] = pcol[r];
            end
            if (tr >= 2 && tr <= h - 1 && tc >= 2)
                for (int k = 0; k < 3; k++) grad[11*k +: 11] = lane_gradient(k);
        end
        qc = (tc == 0 ? w - 1 : tc - 1) % MAX_WIDTH;
        ecol[0] = edge_line[qc];
        ecol[1] = edge_line[MAX_WIDTH + qc];
        ecol[2] = grad;
        edge_line[qc] = ecol[1];
        edge_line[MAX_WIDTH + qc] = grad;
        for (int r = 0; r < 3; r++) begin
            edge_win[r*3] = edge_win[r*3+1];
            edge_win[r*3+1] = edge_win[r*3+2];
            edge_win[r*3+2] = ecol[r];
        end
        in_col = tc + 1;
        if (in_col >= w) begin
            in_col = 0; in_row = tr + 1;
        end
        if (tr < 2 || (tr == 2 && tc < 2)) return;
        orow = out_row; ocol = out_col;
        inner = orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2;
        for (int k = 0; k < 3; k++) e.edges[8*k +: 8] = inner ? lane_suppress(k) : 8'd0;
        e.last = (orow == h - 1) && (ocol == w - 1);
        edge_q.push_back(e);
        out_col = ocol + 1;
        if (out_col >= w) begin
            out_col = 0; out_row = orow + 1;
        end
        if (e.last) restart_frame();
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (pixel_q.size() > 0 &&
                !((idle_mode == 1 || idle_mode == 3) &&
                  $urandom_range(99) < (idle_mode == 1 ? 50 : 14))) begin
                pixel_txn_t t;
                t = pixel_q.pop_front();
                items_sent++;
                s_tvalid <= 1;
                s_tuser <= t.drain;
                s_tdata <= {t.blue, t.green, t.red};
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        if (idle_mode == 2) m_tready <= $urandom_range(99) >= 50;
        else if (idle_mode == 3) m_tready <= $urandom_range(99) >= 14;
        else m_tready <= 1;
        if (aresetn && s_tvalid && s_tready) begin
            pixel_txn_t t;
            t.drain = s_tuser;
            {t.blue, t.green, t.red} = s_tdata;
            predict_edges(t);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (edge_q.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                err_count++;
            end else begin
                edge_txn_t e;
                e = edge_q.pop_front();
                if (m_tdata[7:0] !== e.edges[7:0]) begin
                    $error("red_edge exp %0d got %0d", e.edges[7:0], m_tdata[7:0]);
                    err_count++;
                end
                if (m_tdata[15:8] !== e.edges[15:8]) begin
                    $error("green_edge exp %0d got %0d", e.edges[15:8], m_tdata[15:8]);
                    err_count++;
                end
                if (m_tdata[23:16] !== e.edges[23:16]) begin
                    $error("blue_edge exp %0d got %0d", e.edges[23:16], m_tdata[23:16]);
                    err_count++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_of_frame exp %0d got %0d", e.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_W'(idx * 4); pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_IDX_WIDTH:  cfg_width = value[10:0];
            REG_IDX_HEIGHT: cfg_height = value[15:0];
            REG_IDX_THRESH: cfg_thresh = value[8:0];
            default: ;
        endcase
        restart_frame();
    endtask

    task automatic configure(int w, int h, int thr);
        apb_write(REG_IDX_WIDTH, w);
        apb_write(REG_IDX_HEIGHT, h);
        apb_write(REG_IDX_THRESH, thr);
    endtask

    task automatic wait_idle();
        while (pixel_q.size() > 0 || s_tvalid || edge_q.size() > 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    function automatic pixel_txn_t make_pixel(int style, int x, int y);
        pixel_txn_t t;
        t.drain = 0;
        case (style)
            0: begin
                t.red = 8'($urandom); t.green = 8'($urandom); t.blue = 8'($urandom);
            end
            1: begin
                t.red = ((x + y) % 2) ? 8'd255 : 8'd0;
                t.green = (x % 2) ? 8'd255 : 8'd0;
                t.blue = (y % 2) ? 8'd0 : 8'd255;
            end
            default: begin
                t.red = 8'(x * 37 + y * 11 + $urandom_range(3));
                t.green = 8'(x * x * 5 + y * 23);
                t.blue = (y > x) ? 8'(200 + $urandom_range(55)) : 8'($urandom_range(40));
            end
        endcase
        return t;
    endfunction

    // one frame of pixels then its drains, with stray items mixed in
    task automatic queue_frame(int style, int noise);
        int w, h;
        pixel_txn_t t;
        w = width_used(); h = height_used();
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
                if ($urandom_range(99) < noise) begin
                    t = make_pixel(0, 0, 0);
                    t.drain = 1;
                    pixel_q.push_back(t);
                end
                pixel_q.push_back(make_pixel(style, x, y));
            end
        for (int i = 0; i < 2 * w + 2; i++) begin
            if ($urandom_range(99) < noise) pixel_q.push_back(make_pixel(0, 0, 0));
            t = make_pixel(0, 0, 0);
            t.drain = 1;
            pixel_q.push_back(t);
        end
    endtask

    initial begin
        pixel_txn_t t;
        int w, h;
        for (int i = 0; i < 2 * MAX_WIDTH; i++) begin
            pix_line[i] = '0; edge_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) begin
            pix_win[i] = '0; edge_win[i] = '0;
        end
        restart_frame();
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset settings: a few pixels and an early drain that is ignored
        for (int i = 0; i < 4; i++) pixel_q.push_back(make_pixel(1, i, 0));
        t = make_pixel(0, 0, 0);
        t.drain = 1;
        pixel_q.push_back(t);
        wait_idle();

        // smallest frame, extremes of the samples, stray pixel during drain
        configure(3, 3, 0);
        queue_frame(1, 0);
        pixel_q.insert(pixel_q.size() - 3, make_pixel(0, 0, 0));
        wait_idle();

        // clamped width and height, highest threshold
        configure(0, 0, 340);
        queue_frame(1, 20);
        wait_idle();
        configure(2, 1, 511);
        queue_frame(0, 10);
        wait_idle();

        // tallest frame, left unfinished
        configure(5, 65535, 1);
        for (int i = 0; i < 40; i++) pixel_q.push_back(make_pixel(2, i % 5, i / 5));
        wait_idle();

        // width clamped to the maximum, frame left unfinished
        idle_mode = 3;
        configure(2047, 3, 0);
        for (int i = 0; i < 200; i++) pixel_q.push_back(make_pixel(0, 0, 0));
        wait_idle();

        // wider frame
        configure(60, 4, 0);
        queue_frame(0, 2);
        wait_idle();

        for (int f = 0; items_sent < 1750; f++) begin
            idle_mode = f % 4;
            w = (f % 9 == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            configure(w, h, $urandom_range(99) < 20 ? $urandom_range(0, 511)
                                                     : $urandom_range(0, 60));
            queue_frame($urandom_range(2), $urandom_range(99) < 70 ? 0 : 8);
            if ($urandom_range(3) == 0) queue_frame($urandom_range(2), 0);
            wait_idle();
        end

        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

[filelist.f]
hdl/cse_pkg.sv
hdl/cse_grad_lane.sv
hdl/cse_nms_lane.sv
hdl/cse_out_fifo.sv
hdl/color_sobel_edge_nms.sv
hdl/cse_checker.sv
tb/color_sobel_edge_nms_tb.sv
